// ===== hdl/stb_pkg.sv =====
`default_nettype none

package stb_pkg;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_START  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e;

    // At most this many expiries are reported for one tick
    localparam int MAX_FIRES = 8;

    // One result beat as it leaves the controller
    typedef struct packed {
        cmd_e        cmd;
        logic        status;
        logic [2:0]  timer_slot;
        logic        fired;
        logic [31:0] tick_now;
        logic        last;
    } res_t;

    // Status codes
    localparam logic ST_PASS = 1'b0;
    localparam logic ST_FAIL = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/stb_ram.sv =====
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/stb_out.sv =====
`default_nettype none

module stb_out
    import stb_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire res_t res,
    output logic      in_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_res
);

    logic m_valid_reg;
    logic m_valid_next;
    res_t res_reg;

    // Free when empty or when the held beat leaves this cycle
    assign in_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load payload on push only
    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

// ===== hdl/stb_ctrl.sv =====
`default_nettype none

module stb_ctrl
    import stb_pkg::*;
#(
    parameter int NUM_SLOTS  = 8,
    parameter int TICK_WIDTH = 32,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // command side
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire cmd_e                    cmd,
    input  wire logic [31:0]             period,
    input  wire logic                    auto_reload,
    input  wire logic [2:0]              slot_select,
    // result side
    output logic                         push,
    output res_t                         res,
    input  wire logic                    out_ready,
    // slot memory: {period, expiry}
    output logic                         ram_we,
    output logic [SW-1:0]                ram_waddr,
    output logic [2*TICK_WIDTH-1:0]      ram_wdata,
    output logic                         ram_re,
    output logic [SW-1:0]                ram_raddr,
    input  wire logic [2*TICK_WIDTH-1:0] ram_rdata
);

    localparam int TW  = TICK_WIDTH;
    localparam int TNW = (TW > 32) ? TW : 32;
    localparam int IXW = (SW > 3) ? SW : 3;
    localparam int SXW = (SW > 3) ? SW : 3;
    localparam int FCW = $clog2(MAX_FIRES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FINAL = 4'b1000
    } state_t;

    typedef struct packed {
        logic       status;
        logic [2:0] timer_slot;
        logic       fired;
    } fin_t;

    state_t         state_reg, state_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] reload_reg, reload_next;
    logic [TW-1:0]  tick_reg, tick_next;
    logic [FCW-1:0] fire_cnt_reg, fire_cnt_next;
    logic           hold_valid_reg, hold_valid_next;
    logic [2:0]     hold_slot_reg, hold_slot_next;
    cmd_e           cmd_reg, cmd_next;
    fin_t           fin_reg, fin_next;
    logic [SW-1:0]  idx_reg, idx_next;

    logic [TNW-1:0] tick_ext;
    logic [31:0]    tick32;
    logic [TNW-1:0] per_ext;
    logic [TW-1:0]  per_m;
    logic [SXW-1:0] sel_ext;
    logic [SW-1:0]  sel_idx;
    logic           sel_ok;
    logic [SW-1:0]  free_idx;
    logic           free_found;
    logic [TW-1:0]  rd_per;
    logic [TW-1:0]  rd_exp;
    logic           fire_cand;
    logic           last_slot;
    logic           stall;

    // Report a slot index modulo eight
    function automatic logic [2:0] slot3(input logic [SW-1:0] idx);
        logic [IXW-1:0] t;
        t = IXW'(idx);
        return t[2:0];
    endfunction

    assign tick_ext = TNW'(tick_reg);
    assign tick32   = tick_ext[31:0];
    assign per_ext  = TNW'(period);
    assign per_m    = per_ext[TW-1:0];
    assign sel_ext  = SXW'(slot_select);
    assign sel_idx  = sel_ext[SW-1:0];
    assign sel_ok   = ({29'd0, slot_select} < 32'(NUM_SLOTS));
    assign rd_per   = ram_rdata[2*TW-1:TW];
    assign rd_exp   = ram_rdata[TW-1:0];

    // Lowest free slot
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx   = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    // Scan stage: slot in idx_reg has its memory word in ram_rdata
    assign fire_cand = used_reg[idx_reg] && active_reg[idx_reg] && (tick_reg >= rd_exp)
                       && (fire_cnt_reg < FCW'(MAX_FIRES));
    assign last_slot = (idx_reg == SW'(NUM_SLOTS - 1));
    assign stall     = fire_cand && hold_valid_reg && !out_ready;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        active_next     = active_reg;
        reload_next     = reload_reg;
        tick_next       = tick_reg;
        fire_cnt_next   = fire_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        cmd_next        = cmd_reg;
        fin_next        = fin_reg;
        idx_next        = idx_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        push            = 1'b0;
        res             = '{cmd: cmd_reg, status: ST_PASS, timer_slot: 3'd0, fired: 1'b0,
                            tick_now: tick32, last: 1'b0};

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = cmd;
                    case (cmd)
                        CMD_CREATE: begin
                            if (!free_found || per_m == '0) begin
                                fin_next = '{status: ST_FAIL, timer_slot: 3'd0, fired: 1'b0};
                            end else begin
                                used_next[free_idx]   = 1'b1;
                                active_next[free_idx] = 1'b0;
                                reload_next[free_idx] = auto_reload;
                                ram_we    = 1'b1;
                                ram_waddr = free_idx;
                                ram_wdata = {per_m, {TW{1'b0}}};
                                fin_next  = '{status: ST_PASS, timer_slot: slot3(free_idx),
                                              fired: 1'b0};
                            end
                            state_next = S_FINAL;
                        end
                        CMD_START: begin
                            if (!sel_ok) begin
                                fin_next   = '{status: ST_FAIL, timer_slot: slot_select,
                                               fired: 1'b0};
                                state_next = S_FINAL;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = sel_idx;
                                idx_next   = sel_idx;
                                state_next = S_START;
                            end
                        end
                        CMD_TICK: begin
                            tick_next       = TW'(tick_reg + 1'b1);
                            ram_re          = 1'b1;
                            ram_raddr       = '0;
                            idx_next        = '0;
                            fire_cnt_next   = '0;
                            hold_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default: begin
                            used_next   = '0;
                            active_next = '0;
                            reload_next = '0;
                            tick_next   = '0;
                            fin_next    = '{status: ST_PASS, timer_slot: 3'd0, fired: 1'b0};
                            state_next  = S_FINAL;
                        end
                    endcase
                end
            end

            S_START: begin
                // Arm: expiry is tick plus the stored period
                ram_we               = 1'b1;
                ram_waddr            = idx_reg;
                ram_wdata            = {rd_per, TW'(tick_reg + rd_per)};
                active_next[idx_reg] = 1'b1;
                fin_next   = '{status: ST_PASS, timer_slot: slot3(idx_reg), fired: 1'b0};
                state_next = S_FINAL;
            end

            S_SCAN: begin
                if (!stall) begin
                    if (fire_cand) begin
                        // Reload or disarm the expiring slot
                        if (reload_reg[idx_reg]) begin
                            ram_we    = 1'b1;
                            ram_waddr = idx_reg;
                            ram_wdata = {rd_per, TW'(rd_exp + rd_per)};
                        end else begin
                            active_next[idx_reg] = 1'b0;
                        end
                        fire_cnt_next = FCW'(fire_cnt_reg + 1'b1);
                        // Release the earlier fire, now known not to be last
                        if (hold_valid_reg) begin
                            push = 1'b1;
                            res  = '{cmd: cmd_reg, status: ST_PASS, timer_slot: hold_slot_reg,
                                     fired: 1'b1, tick_now: tick32, last: 1'b0};
                        end
                        hold_slot_next  = slot3(idx_reg);
                        hold_valid_next = 1'b1;
                    end
                    if (!last_slot) begin
                        ram_re    = 1'b1;
                        ram_raddr = SW'(idx_reg + 1'b1);
                        idx_next  = SW'(idx_reg + 1'b1);
                    end else begin
                        hold_valid_next = 1'b0;
                        if (fire_cand) begin
                            fin_next = '{status: ST_PASS, timer_slot: slot3(idx_reg),
                                         fired: 1'b1};
                        end else if (hold_valid_reg) begin
                            fin_next = '{status: ST_PASS, timer_slot: hold_slot_reg,
                                         fired: 1'b1};
                        end else begin
                            fin_next = '{status: ST_PASS, timer_slot: 3'd0, fired: 1'b0};
                        end
                        state_next = S_FINAL;
                    end
                end
            end

            S_FINAL: begin
                if (out_ready) begin
                    push = 1'b1;
                    res  = '{cmd: cmd_reg, status: fin_reg.status,
                             timer_slot: fin_reg.timer_slot, fired: fin_reg.fired,
                             tick_now: tick32, last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            active_reg     <= '0;
            reload_reg     <= '0;
            tick_reg       <= '0;
            fire_cnt_reg   <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            active_reg     <= active_next;
            reload_reg     <= reload_next;
            tick_reg       <= tick_next;
            fire_cnt_reg   <= fire_cnt_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        fin_reg       <= fin_next;
        idx_reg       <= idx_next;
        hold_slot_reg <= hold_slot_next;
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_ready)
        else $error("result pushed while output register is full");

    a_fire_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= FCW'(MAX_FIRES))
        else $error("fire count beyond cap");

    a_hold_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_SCAN) |-> !hold_valid_reg)
        else $error("pending fire outside a tick scan");

    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && cmd == CMD_TICK) |=>
            (state_reg == S_SCAN) && (tick_reg == TW'($past(tick_reg) + 1'b1)))
        else $error("tick did not advance into scan");

    a_mid_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !res.last) |-> (res.fired && state_reg == S_SCAN))
        else $error("non-final beat that is not a fire");
`endif

endmodule

`default_nettype wire

// ===== hdl/software_timer_bank_top.sv =====
`default_nettype none

// Bank of NUM_SLOTS timer slots driven by command beats. Create takes the
// lowest free slot, start arms a slot at tick plus period, tick advances the
// count and reports every expiring slot in index order (at most eight per
// tick, fired=1, tlast on the final one, or one beat with fired=0 when none
// expire), clear empties the bank and zeroes the tick. Slot periods and
// expiries live in one memory with a registered read; one command
// is processed at a time. A tick scans the slots in index order, reading
// one slot per cycle from the memory port unless a fire waits on output
// back-pressure. The next command is accepted the cycle after the last
// result is loaded into the output register, even while it waits.
module software_timer_bank_top
    import stb_pkg::*;
#(
    parameter int NUM_SLOTS  = 8,
    parameter int TICK_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // period[31:0], auto_reload[32], slot_select[35:33]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // status[0], timer_slot[3:1], fired[4], tick_now[36:5]
    output logic      [1:0]  m_tuser,   // command_echo[1:0]
    output logic             m_tlast
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RW = 2 * TICK_WIDTH;

    logic          push;
    res_t          res;
    res_t          m_res;
    logic          out_ready;
    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic          ram_re;
    logic [SW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    stb_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .TICK_WIDTH(TICK_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .cmd        (cmd_e'(s_tuser)),
        .period     (s_tdata[31:0]),
        .auto_reload(s_tdata[32]),
        .slot_select(s_tdata[35:33]),
        .push       (push),
        .res        (res),
        .out_ready  (out_ready),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    stb_ram #(
        .WIDTH(RW),
        .DEPTH(NUM_SLOTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    stb_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .res     (res),
        .in_ready(out_ready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    // Pack the result beat
    assign m_tdata = {3'b000, m_res.tick_now, m_res.fired, m_res.timer_slot, m_res.status};
    assign m_tuser = m_res.cmd;
    assign m_tlast = m_res.last;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top
    import stb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = 8;
    localparam int RANDOM_ITEMS = 420;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Suppress idling on both sides while set
    bit calm = 1'b0;

    // Shadow copy of the timer bank and the queue of result beats it predicts
    class timer_bank_shadow;
        bit        used   [NUM_SLOTS];
        bit        active [NUM_SLOTS];
        bit        reload [NUM_SLOTS];
        bit [31:0] period [NUM_SLOTS];
        bit [31:0] expiry [NUM_SLOTS];
        bit [31:0] tick;
        res_t      awaited_beats[$];
        int        errors;

        function void wipe();
            foreach (used[i]) begin
                used[i]   = 1'b0;
                active[i] = 1'b0;
                reload[i] = 1'b0;
                period[i] = '0;
                expiry[i] = '0;
            end
            tick = '0;
        endfunction

        function new();
            wipe();
            errors = 0;
        endfunction

        function void await_beat(cmd_e c, logic st, logic [2:0] slot, logic fire, logic fin);
            res_t b;
            b.cmd        = c;
            b.status     = st;
            b.timer_slot = slot;
            b.fired      = fire;
            b.tick_now   = tick;
            b.last       = fin;
            awaited_beats.push_back(b);
        endfunction

        // Apply one accepted command and queue the beats it should produce
        function void note_command(cmd_e c, bit [31:0] per, bit rel, bit [2:0] sel);
            int free_slot;
            int fires;
            free_slot = -1;
            fires = 0;
            case (c)
                CMD_CREATE: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!used[i] && free_slot < 0) free_slot = i;
                    end
                    if (free_slot < 0 || per == 0) begin
                        await_beat(c, ST_FAIL, 3'd0, 1'b0, 1'b1);
                    end else begin
                        used[free_slot]   = 1'b1;
                        active[free_slot] = 1'b0;
                        reload[free_slot] = rel;
                        period[free_slot] = per;
                        expiry[free_slot] = '0;
                        await_beat(c, ST_PASS, free_slot[2:0], 1'b0, 1'b1);
                    end
                end
                CMD_START: begin
                    if (sel >= NUM_SLOTS) begin
                        await_beat(c, ST_FAIL, sel, 1'b0, 1'b1);
                    end else begin
                        expiry[sel] = tick + period[sel];
                        active[sel] = 1'b1;
                        await_beat(c, ST_PASS, sel, 1'b0, 1'b1);
                    end
                end
                CMD_TICK: begin
                    tick = tick + 1;
                    for (int i = 0; i < NUM_SLOTS && fires < MAX_FIRES; i++) begin
                        if (used[i] && active[i] && tick >= expiry[i]) begin
                            if (reload[i]) expiry[i] = expiry[i] + period[i];
                            else active[i] = 1'b0;
                            await_beat(c, ST_PASS, i[2:0], 1'b1, 1'b0);
                            fires++;
                        end
                    end
                    if (fires == 0) await_beat(c, ST_PASS, 3'd0, 1'b0, 1'b1);
                    else awaited_beats[awaited_beats.size() - 1].last = 1'b1;
                end
                default: begin
                    wipe();
                    await_beat(c, ST_PASS, 3'd0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void match(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                errors++;
            end
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_beat(logic [1:0] user, logic [39:0] data, logic tlast);
            res_t want;
            if (awaited_beats.size() == 0) begin
                $error("result beat with nothing expected: tuser %0h tdata %0h", user, data);
                errors++;
                return;
            end
            want = awaited_beats.pop_front();
            match("command_echo", 32'(want.cmd), 32'(user));
            match("status", 32'(want.status), 32'(data[0]));
            match("timer_slot", 32'(want.timer_slot), 32'(data[3:1]));
            match("fired", 32'(want.fired), 32'(data[4]));
            match("tick_now", want.tick_now, data[36:5]);
            match("last", 32'(want.last), 32'(tlast));
        endfunction
    endclass

    timer_bank_shadow shadow = new();

    software_timer_bank_top #(
        .NUM_SLOTS (NUM_SLOTS),
        .TICK_WIDTH(32)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),    // period[31:0], auto_reload[32], slot_select[35:33]
        .s_tuser (s_tuser),    // command[1:0]
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),    // status[0], timer_slot[3:1], fired[4], tick_now[36:5]
        .m_tuser (m_tuser),    // command_echo[1:0]
        .m_tlast (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stall the result side at random unless calm
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 33);
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) shadow.check_beat(m_tuser, m_tdata, m_tlast);
    end

    // Drive one command beat, hold it until accepted, then record it
    task automatic send_command(cmd_e c, bit [31:0] per, bit rel, bit [2:0] sel);
        while (!calm && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, sel, rel, per};
        s_tuser  <= c;
        do @(posedge aclk); while (!s_tready);
        shadow.note_command(c, per, rel, sel);
    endtask

    task automatic run_directed();
        // Zero period is rejected
        send_command(CMD_CREATE, 32'd0, 1'b1, 3'd0);
        // Fill the table: slot 0 with the largest period, the rest with period one
        send_command(CMD_CREATE, 32'hFFFF_FFFF, 1'b1, 3'd7);
        for (int i = 1; i < NUM_SLOTS; i++) begin
            send_command(CMD_CREATE, 32'd1, i[0], 3'd0);
        end
        // Table full
        send_command(CMD_CREATE, 32'd5, 1'b0, 3'd0);
        send_command(CMD_TICK, 32'd0, 1'b0, 3'd0);
        // Slot 0 expiry wraps past zero, so it fires at once
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_command(CMD_START, 32'd0, 1'b0, i[2:0]);
        end
        // Every slot fires in one tick, then only the reloading slots of period one
        send_command(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 3'd7);
        send_command(CMD_TICK, 32'd0, 1'b0, 3'd0);
        send_command(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, 3'd7);
        // Arm an unused slot, then create over it
        send_command(CMD_START, 32'd0, 1'b0, 3'd0);
        send_command(CMD_CREATE, 32'd4, 1'b0, 3'd5);
        send_command(CMD_TICK, 32'd0, 1'b0, 3'd0);
    endtask

    task automatic random_item();
        cmd_e      c;
        bit [31:0] per;
        int        pick;
        pick = $urandom_range(0, 99);
        per  = $urandom();
        if (pick < 22) c = CMD_CREATE;
        else if (pick < 47) c = CMD_START;
        else if (pick < 95) c = CMD_TICK;
        else c = CMD_CLEAR;
        if (c == CMD_CREATE) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) per = $urandom_range(1, 8);
            else if (pick < 80) per = '0;
        end
        send_command(c, per, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    endtask

    initial begin
        int guard;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        // Random commands, with a stretch of full rate on both sides
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 150 && n < 250);
            random_item();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        // Drain the outstanding results, then watch for stray beats
        guard = 0;
        while (shadow.awaited_beats.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (NUM_SLOTS + 8) @(posedge aclk);
        if (shadow.awaited_beats.size() != 0) begin
            $error("%0d result beats never arrived", shadow.awaited_beats.size());
            shadow.errors++;
        end
        if (shadow.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
